FILE: hdl/rcsp_pkg.sv
// ----------------------------------------------------------------------------
// rcsp_pkg
// shared widths, constants, codes and helpers of the shortest path engine
// ----------------------------------------------------------------------------
`default_nettype none

package rcsp_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_COINS  = 2048;
  localparam int MAX_EDGES  = 256;
  localparam int HEAP_DEPTH = 65536;

  localparam int NODE_W     = 6;
  localparam int NCNT_W     = 7;
  localparam int COIN_W     = 11;
  localparam int DUR_W      = 32;
  localparam int TIME_W     = 47;
  localparam int KEY_W      = TIME_W + NODE_W + COIN_W;
  localparam int DIST_AW    = NODE_W + COIN_W;
  localparam int EDGE_AW    = 8;
  localparam int EDGE_CNT_W = 9;
  localparam int HEAP_AW    = 16;
  localparam int HEAP_CNT_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [TIME_W-1:0] TIME_ALL = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ADD_EDGE  = 2'd0,
    KIND_SET_XCH   = 2'd1,
    KIND_RUN       = 2'd2,
    KIND_CLR_EDGES = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COINS = 2'd1;

  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [COIN_W-1:0] fare;
    logic [DUR_W-1:0]  dur;
  } edge_t;

  typedef struct packed {
    logic [COIN_W-1:0] coins;
    logic [DUR_W-1:0]  dur;
  } xch_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DUR_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W+1-DUR_W){1'b0}}, d};
    return s[TIME_W] ? TIME_ALL : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rcsp_ram.sv
// ----------------------------------------------------------------------------
// rcsp_ram
// generic one write, one read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hdl/resource_constrained_shortest_path.sv
// ----------------------------------------------------------------------------
// resource_constrained_shortest_path
// dijkstra over (node, coin balance) with per node coin exchange
// ----------------------------------------------------------------------------
// Load beats (add edge, set exchange, clear edge list) stay in idle and can
// follow back to back. A run beat first sweeps the distance memory back to all
// ones, one entry a cycle, then walks the search. A heap pop runs POP0, POP1,
// POP2, per sift-down level SD_CHK, SD_R1, SD_R2 (second child only) and
// SD_CMP, then SD_WR, then the stale check CHK_RD, CHK; a stale entry stops
// there. A pop that empties the heap skips the sift-down, and the final pop
// of an empty heap ends in POP0. A relaxation runs RX_RD, RX_CMP; a push adds
// PU_CHK, per sift-up level PU_CMP and PU_CHK, then PU_WR. A live entry then
// scans the whole edge list, EDGE_RD and EDGE_A per edge, EDGE_B for an edge
// that can be taken. Results then come one node at a time, each after a scan
// over all balances of that node. No input beat is taken during a run. A
// single sequencer drives one read and one write port on each of four memories
// (edges, exchanges, distances, heap), which bounds the rate. min_time all
// ones means unreachable or saturated; heap_overflow reports a dropped push.
`default_nettype none

module resource_constrained_shortest_path
  import rcsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_kind,
  input  wire logic [NODE_W-1:0]     in_first_node,
  input  wire logic [NODE_W-1:0]     in_second_node,
  input  wire logic [COIN_W-1:0]     in_coin_amount,
  input  wire logic [DUR_W-1:0]      in_time_amount,
  // result beats
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [NODE_W-1:0]          out_node_index,
  output logic [TIME_W-1:0]          out_min_time,
  output logic                       out_heap_overflow,
  output logic                       out_last
);

  typedef enum logic [22:0] {
    S_IDLE     = 23'h000001,
    S_CLR      = 23'h000002,
    S_RX_RD    = 23'h000004,
    S_RX_CMP   = 23'h000008,
    S_PU_CHK   = 23'h000010,
    S_PU_CMP   = 23'h000020,
    S_PU_WR    = 23'h000040,
    S_POP0     = 23'h000080,
    S_POP1     = 23'h000100,
    S_POP2     = 23'h000200,
    S_SD_CHK   = 23'h000400,
    S_SD_R1    = 23'h000800,
    S_SD_R2    = 23'h001000,
    S_SD_CMP   = 23'h002000,
    S_SD_WR    = 23'h004000,
    S_CHK_RD   = 23'h008000,
    S_CHK      = 23'h010000,
    S_EDGE_RD  = 23'h020000,
    S_EDGE_A   = 23'h040000,
    S_EDGE_B   = 23'h080000,
    S_OUT_INIT = 23'h100000,
    S_MIN      = 23'h200000,
    S_OUT      = 23'h400000
  } state_t;

  localparam logic [COIN_W-1:0] COIN_TOP = COIN_W'(MAX_COINS - 1);

  // registers
  state_t                  state_r, state_nxt, ret_r, ret_nxt;
  logic [NCNT_W-1:0]       node_count_r, node_count_nxt;
  logic [COIN_W-1:0]       start_coins_r, start_coins_nxt;
  logic [NCNT_W-1:0]       n_r, n_nxt;
  logic [EDGE_CNT_W-1:0]   edge_count_r, edge_count_nxt;
  logic [MAX_NODES-1:0]    xch_valid_r, xch_valid_nxt;
  logic [HEAP_CNT_W-1:0]   size_r, size_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [DIST_AW-1:0]      cl_r, cl_nxt;
  logic [TIME_W-1:0]       cur_t_r, cur_t_nxt;
  logic [NODE_W-1:0]       cur_v_r, cur_v_nxt;
  logic [COIN_W-1:0]       cur_c_r, cur_c_nxt;
  logic [NODE_W-1:0]       rx_node_r, rx_node_nxt;
  logic [COIN_W-1:0]       rx_coins_r, rx_coins_nxt;
  logic [TIME_W-1:0]       rx_t_r, rx_t_nxt;
  logic [HEAP_CNT_W-1:0]   hi_r, hi_nxt;
  logic [KEY_W-1:0]        hkey_r, hkey_nxt;
  logic [HEAP_CNT_W:0]     hc_r, hc_nxt;
  logic [KEY_W-1:0]        hcd_r, hcd_nxt;
  logic [EDGE_CNT_W-1:0]   k_r, k_nxt;
  edge_t                   edge_r, edge_nxt;
  logic [NCNT_W-1:0]       oi_r, oi_nxt;
  logic [COIN_W:0]         j_r, j_nxt;
  logic [TIME_W-1:0]       best_r, best_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]       out_node_r, out_node_nxt;
  logic [TIME_W-1:0]       out_time_r, out_time_nxt;
  logic                    out_ovf_r, out_ovf_nxt;
  logic                    out_last_r, out_last_nxt;

  // memory ports
  logic                    ed_we;
  logic [EDGE_AW-1:0]      ed_wa, ed_ra;
  edge_t                   ed_wd, ed_q;
  logic                    xc_we;
  logic [NODE_W-1:0]       xc_wa, xc_ra;
  xch_t                    xc_wd, xc_q;
  logic                    ds_we;
  logic [DIST_AW-1:0]      ds_wa, ds_ra;
  logic [TIME_W-1:0]       ds_wd, ds_q;
  logic                    hp_we;
  logic [HEAP_AW-1:0]      hp_wa, hp_ra;
  logic [KEY_W-1:0]        hp_wd, hp_q;

  rcsp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .wr_en(ed_we), .wr_addr(ed_wa), .wr_data(ed_wd), .rd_addr(ed_ra), .rd_data(ed_q)
  );
  rcsp_ram #(.WIDTH($bits(xch_t)), .DEPTH(MAX_NODES)) u_xch_ram (
    .clk, .wr_en(xc_we), .wr_addr(xc_wa), .wr_data(xc_wd), .rd_addr(xc_ra), .rd_data(xc_q)
  );
  rcsp_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES * MAX_COINS)) u_dist_ram (
    .clk, .wr_en(ds_we), .wr_addr(ds_wa), .wr_data(ds_wd), .rd_addr(ds_ra), .rd_data(ds_q)
  );
  rcsp_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk, .wr_en(hp_we), .wr_addr(hp_wa), .wr_data(hp_wd), .rd_addr(hp_ra), .rd_data(hp_q)
  );

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_node_index    = out_node_r;
  assign out_min_time      = out_time_r;
  assign out_heap_overflow = out_ovf_r;
  assign out_last          = out_last_r;

  // helper values
  logic [HEAP_CNT_W-1:0]   parent;
  logic [HEAP_CNT_W:0]     child;
  logic [HEAP_CNT_W:0]     child_nb;
  logic [HEAP_CNT_W-1:0]   size_dec;
  logic [COIN_W-1:0]       xc_coins;
  logic [DUR_W-1:0]        xc_dur;
  logic [COIN_W:0]         xc_sum;
  logic                    edge_ok;
  logic [NCNT_W-1:0]       n_clamp;

  assign parent   = (hi_r - 1'b1) >> 1;
  assign child    = {hi_r, 1'b1};
  assign child_nb = hc_r + 1'b1;
  assign size_dec = size_r - 1'b1;
  assign xc_coins = xch_valid_r[cur_v_r] ? xc_q.coins : '0;
  assign xc_dur   = xch_valid_r[cur_v_r] ? xc_q.dur : '0;
  assign xc_sum   = {1'b0, cur_c_r} + {1'b0, xc_coins};
  assign edge_ok  = ({1'b0, ed_q.a} < n_r) && ({1'b0, ed_q.b} < n_r) &&
                    (cur_c_r >= ed_q.fare);
  assign n_clamp  = (node_count_r == '0) ? NCNT_W'(1) :
                    (node_count_r > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) :
                    node_count_r;

  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    node_count_nxt  = node_count_r;
    start_coins_nxt = start_coins_r;
    n_nxt           = n_r;
    edge_count_nxt  = edge_count_r;
    xch_valid_nxt   = xch_valid_r;
    size_nxt        = size_r;
    ovf_nxt         = ovf_r;
    cl_nxt          = cl_r;
    cur_t_nxt       = cur_t_r;
    cur_v_nxt       = cur_v_r;
    cur_c_nxt       = cur_c_r;
    rx_node_nxt     = rx_node_r;
    rx_coins_nxt    = rx_coins_r;
    rx_t_nxt        = rx_t_r;
    hi_nxt          = hi_r;
    hkey_nxt        = hkey_r;
    hc_nxt          = hc_r;
    hcd_nxt         = hcd_r;
    k_nxt           = k_r;
    edge_nxt        = edge_r;
    oi_nxt          = oi_r;
    j_nxt           = j_r;
    best_nxt        = best_r;
    out_valid_nxt   = out_valid_r;
    out_node_nxt    = out_node_r;
    out_time_nxt    = out_time_r;
    out_ovf_nxt     = out_ovf_r;
    out_last_nxt    = out_last_r;

    ed_we = 1'b0;
    ed_wa = edge_count_r[EDGE_AW-1:0];
    ed_wd = '{a: in_first_node, b: in_second_node, fare: in_coin_amount,
              dur: in_time_amount};
    ed_ra = k_r[EDGE_AW-1:0];
    xc_we = 1'b0;
    xc_wa = in_first_node;
    xc_wd = '{coins: in_coin_amount, dur: in_time_amount};
    xc_ra = cur_v_r;
    ds_we = 1'b0;
    ds_wa = cl_r;
    ds_wd = TIME_ALL;
    ds_ra = {rx_node_r, rx_coins_r};
    hp_we = 1'b0;
    hp_wa = hi_r[HEAP_AW-1:0];
    hp_wd = hkey_r;
    hp_ra = '0;

    // configuration writes
    if (cfg_valid) begin
      if (cfg_index == REG_NODE_COUNT) begin
        node_count_nxt = cfg_data[NCNT_W-1:0];
      end else if (cfg_index == REG_START_COINS) begin
        start_coins_nxt = cfg_data[COIN_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_ADD_EDGE: begin
              if ((edge_count_r < EDGE_CNT_W'(MAX_EDGES)) &&
                  ({1'b0, in_first_node} < NCNT_W'(MAX_NODES)) &&
                  ({1'b0, in_second_node} < NCNT_W'(MAX_NODES))) begin
                ed_we          = 1'b1;
                edge_count_nxt = edge_count_r + 1'b1;
              end
            end
            KIND_SET_XCH: begin
              if ({1'b0, in_first_node} < NCNT_W'(MAX_NODES)) begin
                xc_we                        = 1'b1;
                xch_valid_nxt[in_first_node] = 1'b1;
              end
            end
            KIND_RUN: begin
              n_nxt     = n_clamp;
              cl_nxt    = '0;
              size_nxt  = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_CLR;
            end
            default: begin
              edge_count_nxt = '0;
            end
          endcase
        end
      end

      // distance memory back to all ones
      S_CLR: begin
        ds_we  = 1'b1;
        cl_nxt = cl_r + 1'b1;
        if (cl_r == {DIST_AW{1'b1}}) begin
          rx_node_nxt  = '0;
          rx_coins_nxt = (start_coins_r > COIN_TOP) ? COIN_TOP : start_coins_r;
          rx_t_nxt     = '0;
          ret_nxt      = S_POP0;
          state_nxt    = S_RX_RD;
        end
      end

      // relaxation: read, compare, then push
      S_RX_RD: begin
        state_nxt = S_RX_CMP;
      end
      S_RX_CMP: begin
        if (rx_t_r < ds_q) begin
          ds_we = 1'b1;
          ds_wa = {rx_node_r, rx_coins_r};
          ds_wd = rx_t_r;
          if (size_r >= HEAP_CNT_W'(HEAP_DEPTH)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ret_r;
          end else begin
            hi_nxt    = size_r;
            size_nxt  = size_r + 1'b1;
            hkey_nxt  = {rx_t_r, rx_node_r, rx_coins_r};
            state_nxt = S_PU_CHK;
          end
        end else begin
          state_nxt = ret_r;
        end
      end

      // sift up
      S_PU_CHK: begin
        hp_ra = parent[HEAP_AW-1:0];
        state_nxt = (hi_r == '0) ? S_PU_WR : S_PU_CMP;
      end
      S_PU_CMP: begin
        if (hp_q <= hkey_r) begin
          state_nxt = S_PU_WR;
        end else begin
          hp_we     = 1'b1;
          hp_wd     = hp_q;
          hi_nxt    = parent;
          state_nxt = S_PU_CHK;
        end
      end
      S_PU_WR: begin
        hp_we     = 1'b1;
        state_nxt = ret_r;
      end

      // pop the least key
      S_POP0: begin
        hp_ra     = '0;
        state_nxt = (size_r == '0) ? S_OUT_INIT : S_POP1;
      end
      S_POP1: begin
        hp_ra     = size_dec[HEAP_AW-1:0];
        cur_t_nxt = hp_q[KEY_W-1 -: TIME_W];
        cur_v_nxt = hp_q[COIN_W +: NODE_W];
        cur_c_nxt = hp_q[COIN_W-1:0];
        size_nxt  = size_dec;
        state_nxt = (size_dec == '0) ? S_CHK_RD : S_POP2;
      end
      S_POP2: begin
        hkey_nxt  = hp_q;
        hi_nxt    = '0;
        state_nxt = S_SD_CHK;
      end

      // sift down
      S_SD_CHK: begin
        hp_ra  = child[HEAP_AW-1:0];
        hc_nxt = child;
        state_nxt = (child >= {1'b0, size_r}) ? S_SD_WR : S_SD_R1;
      end
      S_SD_R1: begin
        hp_ra   = child_nb[HEAP_AW-1:0];
        hcd_nxt = hp_q;
        state_nxt = (child_nb < {1'b0, size_r}) ? S_SD_R2 : S_SD_CMP;
      end
      S_SD_R2: begin
        if (hp_q < hcd_r) begin
          hcd_nxt = hp_q;
          hc_nxt  = child_nb;
        end
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (hkey_r <= hcd_r) begin
          state_nxt = S_SD_WR;
        end else begin
          hp_we     = 1'b1;
          hp_wd     = hcd_r;
          hi_nxt    = hc_r[HEAP_CNT_W-1:0];
          state_nxt = S_SD_CHK;
        end
      end
      S_SD_WR: begin
        hp_we     = 1'b1;
        state_nxt = S_CHK_RD;
      end

      // stale check and exchange
      S_CHK_RD: begin
        ds_ra     = {cur_v_r, cur_c_r};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        k_nxt = '0;
        if (ds_q < cur_t_r) begin
          state_nxt = S_POP0;
        end else if (!xc_sum[COIN_W]) begin
          rx_node_nxt  = cur_v_r;
          rx_coins_nxt = xc_sum[COIN_W-1:0];
          rx_t_nxt     = sat_add(cur_t_r, xc_dur);
          ret_nxt      = S_EDGE_RD;
          state_nxt    = S_RX_RD;
        end else begin
          state_nxt = S_EDGE_RD;
        end
      end

      // edge scan
      S_EDGE_RD: begin
        state_nxt = (k_r >= edge_count_r) ? S_POP0 : S_EDGE_A;
      end
      S_EDGE_A: begin
        edge_nxt = ed_q;
        if (!edge_ok) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_EDGE_RD;
        end else if (ed_q.a == cur_v_r) begin
          rx_node_nxt  = ed_q.b;
          rx_coins_nxt = cur_c_r - ed_q.fare;
          rx_t_nxt     = sat_add(cur_t_r, ed_q.dur);
          ret_nxt      = S_EDGE_B;
          state_nxt    = S_RX_RD;
        end else begin
          state_nxt = S_EDGE_B;
        end
      end
      S_EDGE_B: begin
        k_nxt = k_r + 1'b1;
        if (edge_r.b == cur_v_r) begin
          rx_node_nxt  = edge_r.a;
          rx_coins_nxt = cur_c_r - edge_r.fare;
          rx_t_nxt     = sat_add(cur_t_r, edge_r.dur);
          ret_nxt      = S_EDGE_RD;
          state_nxt    = S_RX_RD;
        end else begin
          state_nxt = S_EDGE_RD;
        end
      end

      // per node minimum over balances
      S_OUT_INIT: begin
        oi_nxt    = NCNT_W'(1);
        j_nxt     = '0;
        best_nxt  = TIME_ALL;
        state_nxt = (n_r <= NCNT_W'(1)) ? S_IDLE : S_MIN;
      end
      S_MIN: begin
        // address issued at j, data of j-1 arrives now
        ds_ra = {oi_r[NODE_W-1:0], j_r[COIN_W-1:0]};
        j_nxt = j_r + 1'b1;
        if ((j_r != '0) && (ds_q < best_r)) begin
          best_nxt = ds_q;
        end
        if (j_r[COIN_W]) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = oi_r[NODE_W-1:0];
          out_time_nxt  = (ds_q < best_r) ? ds_q : best_r;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = (oi_r == n_r - 1'b1);
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          oi_nxt        = oi_r + 1'b1;
          j_nxt         = '0;
          best_nxt      = TIME_ALL;
          state_nxt     = out_last_r ? S_IDLE : S_MIN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ret_r         <= S_IDLE;
      node_count_r  <= NCNT_W'(1);
      start_coins_r <= '0;
      n_r           <= NCNT_W'(1);
      edge_count_r  <= '0;
      xch_valid_r   <= '0;
      size_r        <= '0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ret_r         <= ret_nxt;
      node_count_r  <= node_count_nxt;
      start_coins_r <= start_coins_nxt;
      n_r           <= n_nxt;
      edge_count_r  <= edge_count_nxt;
      xch_valid_r   <= xch_valid_nxt;
      size_r        <= size_nxt;
      ovf_r         <= ovf_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cl_r       <= cl_nxt;
    cur_t_r    <= cur_t_nxt;
    cur_v_r    <= cur_v_nxt;
    cur_c_r    <= cur_c_nxt;
    rx_node_r  <= rx_node_nxt;
    rx_coins_r <= rx_coins_nxt;
    rx_t_r     <= rx_t_nxt;
    hi_r       <= hi_nxt;
    hkey_r     <= hkey_nxt;
    hc_r       <= hc_nxt;
    hcd_r      <= hcd_nxt;
    k_r        <= k_nxt;
    edge_r     <= edge_nxt;
    oi_r       <= oi_nxt;
    j_r        <= j_nxt;
    best_r     <= best_nxt;
    out_node_r <= out_node_nxt;
    out_time_r <= out_time_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/rcsp_checker.sv
// ----------------------------------------------------------------------------
// rcsp_checker
// port level checks of the shortest path engine
// ----------------------------------------------------------------------------
`default_nettype none

module rcsp_checker
  import rcsp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [NODE_W-1:0] out_node_index,
  input wire logic [TIME_W-1:0] out_min_time,
  input wire logic              out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_time) &&
                                $stable(out_node_index))
    else $error("result beat changed while stalled");

  // no input beat taken while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during result phase");

  // node zero is never reported
  a_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_index != '0)
    else $error("result for start node");

  // after the final beat the block returns to idle
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("no return to idle after final beat");

endmodule

bind resource_constrained_shortest_path rcsp_checker u_rcsp_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_node_index,
  .out_min_time, .out_last
);

`default_nettype wire
